// ----- sv/tsce_pkg.sv -----
package tsce_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W    = 5;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [COUNT_W-1:0]    count_t;

    localparam fill_t FILL_FULL = fill_t'(DEPTH);

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_DISP = 2'd2,
        ACT_COPY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SEL_S   = 2'd0,
        SEL_P   = 2'd1,
        SEL_Q   = 2'd2,
        SEL_BAD = 2'd3
    } sel_t;

    typedef enum logic [2:0] {
        STAT_ELEMENT   = 3'd0,
        STAT_POPPED    = 3'd1,
        STAT_OVERFLOW  = 3'd2,
        STAT_UNDERFLOW = 3'd3,
        STAT_EMPTY     = 3'd4,
        STAT_SHORT     = 3'd5,
        STAT_INVALID   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_RESP,
        FSM_POP,
        FSM_DISP,
        FSM_COPY
    } state_t;

endpackage

// ----- sv/tsce_ram.sv -----
module tsce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/triple_stack_copy_engine.sv -----
// Three bounded stacks: source S and targets P and Q.
// An item on the s_ channel selects push, pop, display or copy; each item
// yields zero or more results on the m_ channel, the final one with m_last.
// Push gives no result unless S is full (overflow).
// Pop accepts the item, waits for the registered stack read, then hands the
// popped entry to the output register once that register is free.
// Display walks a stack from the top, one result per entry; copy of count
// entries walks S from the top into the target, followed by a display of the target unless S runs short.
// Each stack lives in a small RAM with a registered read port, and that port
// sets the walking rate of one entry per cycle when the walk is not stalled.
// The block accepts one item at a time; s_ready is high only between items.
// Results pass through an output register, so the next item can be accepted
// while the final result of the previous one still waits on m_ready.
// A stalled receiver simply holds the walk at the current entry whenever a result is due.
// Reset (aresetn low, synchronous) empties all three stacks and drops any
// result that was waiting; the stack RAMs themselves are not cleared.
module triple_stack_copy_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [31:0] s_value,
    input  logic [1:0]         s_stack_sel,
    input  logic [4:0]         s_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_data,
    output logic               m_last
);

    tsce_pkg::state_t  state_reg, state_next;
    tsce_pkg::fill_t   ptr_reg, ptr_next;
    tsce_pkg::count_t  rem_reg, rem_next;
    tsce_pkg::sel_t    sel_reg, sel_next;
    tsce_pkg::status_t resp_reg, resp_next;
    logic              rd_vld_reg, rd_vld_next;
    tsce_pkg::fill_t   s_fill_reg, s_fill_next;
    tsce_pkg::fill_t   p_fill_reg, p_fill_next;
    tsce_pkg::fill_t   q_fill_reg, q_fill_next;

    logic               m_valid_reg, m_valid_next;
    tsce_pkg::status_t  m_status_reg, m_status_next;
    logic signed [31:0] m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic              out_free;
    logic              out_load;
    logic              advance;
    tsce_pkg::idx_t    rd_addr;
    tsce_pkg::fill_t   rd_ptr;
    logic              s_we, p_we, q_we;
    tsce_pkg::data_t   s_rdata, p_rdata, q_rdata, disp_rdata;
    tsce_pkg::fill_t   tgt_fill;
    tsce_pkg::fill_t   sel_fill;

    tsce_ram #(.WIDTH(tsce_pkg::DATA_WIDTH), .DEPTH(tsce_pkg::DEPTH)) u_s_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (tsce_pkg::idx_t'(s_fill_reg)),
        .wdata (tsce_pkg::data_t'(s_value)),
        .raddr (rd_addr),
        .rdata (s_rdata)
    );

    tsce_ram #(.WIDTH(tsce_pkg::DATA_WIDTH), .DEPTH(tsce_pkg::DEPTH)) u_p_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (tsce_pkg::idx_t'(p_fill_reg)),
        .wdata (s_rdata),
        .raddr (rd_addr),
        .rdata (p_rdata)
    );

    tsce_ram #(.WIDTH(tsce_pkg::DATA_WIDTH), .DEPTH(tsce_pkg::DEPTH)) u_q_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tsce_pkg::idx_t'(q_fill_reg)),
        .wdata (s_rdata),
        .raddr (rd_addr),
        .rdata (q_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign tgt_fill = (sel_reg == tsce_pkg::SEL_P) ? p_fill_reg : q_fill_reg;

    always_comb begin
        case (sel_reg)
            tsce_pkg::SEL_P: disp_rdata = p_rdata;
            tsce_pkg::SEL_Q: disp_rdata = q_rdata;
            default:         disp_rdata = s_rdata;
        endcase
    end

    always_comb begin
        case (s_stack_sel)
            tsce_pkg::SEL_P: sel_fill = p_fill_reg;
            tsce_pkg::SEL_Q: sel_fill = q_fill_reg;
            default:         sel_fill = s_fill_reg;
        endcase
    end

    // The read address points one below ptr; when the walk steps this cycle it
    // points two below, at the next entry, so the data is ready in time.
    assign rd_ptr  = advance ? (ptr_reg - tsce_pkg::fill_t'(2))
                             : (ptr_reg - tsce_pkg::fill_t'(1));
    assign rd_addr = tsce_pkg::idx_t'(rd_ptr);

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        rem_next      = rem_reg;
        sel_next      = sel_reg;
        resp_next     = resp_reg;
        s_fill_next   = s_fill_reg;
        p_fill_next   = p_fill_reg;
        q_fill_next   = q_fill_reg;
        s_ready       = 1'b0;
        s_we          = 1'b0;
        p_we          = 1'b0;
        q_we          = 1'b0;
        advance       = 1'b0;
        out_load      = 1'b0;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            tsce_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (tsce_pkg::action_t'(s_action))
                        tsce_pkg::ACT_PUSH: begin
                            if (s_fill_reg == tsce_pkg::FILL_FULL) begin
                                resp_next  = tsce_pkg::STAT_OVERFLOW;
                                state_next = tsce_pkg::FSM_RESP;
                            end else begin
                                s_we        = 1'b1;
                                s_fill_next = s_fill_reg + tsce_pkg::fill_t'(1);
                            end
                        end
                        tsce_pkg::ACT_POP: begin
                            if (s_fill_reg == '0) begin
                                resp_next  = tsce_pkg::STAT_UNDERFLOW;
                                state_next = tsce_pkg::FSM_RESP;
                            end else begin
                                ptr_next   = s_fill_reg;
                                state_next = tsce_pkg::FSM_POP;
                            end
                        end
                        tsce_pkg::ACT_DISP: begin
                            if (s_stack_sel == tsce_pkg::SEL_BAD) begin
                                resp_next  = tsce_pkg::STAT_INVALID;
                                state_next = tsce_pkg::FSM_RESP;
                            end else begin
                                sel_next   = tsce_pkg::sel_t'(s_stack_sel);
                                ptr_next   = sel_fill;
                                state_next = tsce_pkg::FSM_DISP;
                            end
                        end
                        default: begin
                            // Copy to S or to the invalid selector is dropped.
                            if (s_stack_sel == tsce_pkg::SEL_P ||
                                s_stack_sel == tsce_pkg::SEL_Q) begin
                                sel_next   = tsce_pkg::sel_t'(s_stack_sel);
                                ptr_next   = s_fill_reg;
                                rem_next   = s_count;
                                state_next = tsce_pkg::FSM_COPY;
                            end
                        end
                    endcase
                end
            end

            tsce_pkg::FSM_RESP: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = resp_reg;
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    state_next    = tsce_pkg::FSM_IDLE;
                end
            end

            tsce_pkg::FSM_POP: begin
                if (rd_vld_reg && out_free) begin
                    out_load      = 1'b1;
                    m_status_next = tsce_pkg::STAT_POPPED;
                    m_data_next   = 32'(signed'(s_rdata));
                    m_last_next   = 1'b1;
                    s_fill_next   = s_fill_reg - tsce_pkg::fill_t'(1);
                    state_next    = tsce_pkg::FSM_IDLE;
                end
            end

            tsce_pkg::FSM_DISP: begin
                if (ptr_reg == '0) begin
                    if (out_free) begin
                        out_load      = 1'b1;
                        m_status_next = tsce_pkg::STAT_EMPTY;
                        m_data_next   = '0;
                        m_last_next   = 1'b1;
                        state_next    = tsce_pkg::FSM_IDLE;
                    end
                end else if (rd_vld_reg && out_free) begin
                    out_load      = 1'b1;
                    m_status_next = tsce_pkg::STAT_ELEMENT;
                    m_data_next   = 32'(signed'(disp_rdata));
                    m_last_next   = (ptr_reg == tsce_pkg::fill_t'(1));
                    advance       = 1'b1;
                    ptr_next      = ptr_reg - tsce_pkg::fill_t'(1);
                    if (ptr_reg == tsce_pkg::fill_t'(1)) begin
                        state_next = tsce_pkg::FSM_IDLE;
                    end
                end
            end

            tsce_pkg::FSM_COPY: begin
                if (rem_reg == '0) begin
                    ptr_next   = tgt_fill;
                    state_next = tsce_pkg::FSM_DISP;
                end else if (ptr_reg == '0) begin
                    if (out_free) begin
                        out_load      = 1'b1;
                        m_status_next = tsce_pkg::STAT_SHORT;
                        m_data_next   = '0;
                        m_last_next   = 1'b1;
                        state_next    = tsce_pkg::FSM_IDLE;
                    end
                end else if (rd_vld_reg) begin
                    if (tgt_fill == tsce_pkg::FILL_FULL) begin
                        // A full target reports overflow and the walk goes on.
                        if (out_free) begin
                            out_load      = 1'b1;
                            m_status_next = tsce_pkg::STAT_OVERFLOW;
                            m_data_next   = '0;
                            m_last_next   = 1'b0;
                            advance       = 1'b1;
                        end
                    end else begin
                        advance = 1'b1;
                        if (sel_reg == tsce_pkg::SEL_P) begin
                            p_we        = 1'b1;
                            p_fill_next = p_fill_reg + tsce_pkg::fill_t'(1);
                        end else begin
                            q_we        = 1'b1;
                            q_fill_next = q_fill_reg + tsce_pkg::fill_t'(1);
                        end
                    end
                    if (advance) begin
                        ptr_next = ptr_reg - tsce_pkg::fill_t'(1);
                        rem_next = rem_reg - tsce_pkg::count_t'(1);
                    end
                end
            end

            default: begin
                state_next = tsce_pkg::FSM_IDLE;
            end
        endcase
    end

    // Read data matches ptr only once the state register has held the same walking state.
    assign rd_vld_next  = (state_next == state_reg);
    assign m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tsce_pkg::FSM_IDLE;
            rd_vld_reg  <= 1'b0;
            s_fill_reg  <= '0;
            p_fill_reg  <= '0;
            q_fill_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            s_fill_reg  <= s_fill_next;
            p_fill_reg  <= p_fill_next;
            q_fill_reg  <= q_fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        rem_reg      <= rem_next;
        sel_reg      <= sel_next;
        resp_reg     <= resp_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_last   = m_last_reg;

endmodule

// ----- tb/sv/triple_stack_copy_engine_tb.sv -----
`timescale 1ns / 1ps

module triple_stack_copy_engine_tb;

    localparam int STK_S = 0;
    localparam int STK_P = 1;
    localparam int STK_Q = 2;
    localparam int RANDOM_ITEMS = 215;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        tsce_pkg::action_t act;
        tsce_pkg::data_t   value;
        tsce_pkg::sel_t    sel;
        tsce_pkg::count_t  cnt;
    } stack_op_t;

    typedef struct packed {
        tsce_pkg::status_t status;
        tsce_pkg::data_t   data;
        logic              last;
    } stack_report_t;

    typedef struct packed {
        stack_op_t     op;
        int            reps;
        logic          typed;
        stack_report_t typed_report;
    } directed_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = '0;
    logic signed [31:0] s_value = '0;
    logic [1:0]         s_stack_sel = '0;
    logic [4:0]         s_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic signed [31:0] m_data;
    logic               m_last;

    // Own copy of the three stacks, indexed S, P, Q.
    tsce_pkg::data_t stack_mem [3][tsce_pkg::DEPTH];
    int              stack_fill [3];
    stack_report_t   item_reports [$];
    stack_report_t   reports_owed [$];

    directed_row_t directed_rows [$];

    bit calm = 1'b0;
    int stall_left = 0;
    int rx_roll;
    int mismatches = 0;
    int results_checked = 0;
    int overflows_seen = 0;
    int shorts_seen = 0;
    int items_sent = 0;
    int directed_items = 0;

    triple_stack_copy_engine i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value     (s_value),
        .s_stack_sel (s_stack_sel),
        .s_count     (s_count),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_data      (m_data),
        .m_last      (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results still outstanding.", reports_owed.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------- stack predictor

    function automatic void add_report(tsce_pkg::status_t st, tsce_pkg::data_t d);
        stack_report_t rp;
        rp.status = st;
        rp.data   = (st == tsce_pkg::STAT_ELEMENT || st == tsce_pkg::STAT_POPPED) ? d : '0;
        rp.last   = 1'b0;
        item_reports.push_back(rp);
    endfunction

    function automatic void push_entry(int which, tsce_pkg::data_t v);
        if (stack_fill[which] >= tsce_pkg::DEPTH) begin
            add_report(tsce_pkg::STAT_OVERFLOW, '0);
        end else begin
            stack_mem[which][stack_fill[which]] = v;
            stack_fill[which]++;
        end
    endfunction

    function automatic void list_stack(int which);
        int i;
        if (stack_fill[which] == 0) begin
            add_report(tsce_pkg::STAT_EMPTY, '0);
        end else begin
            for (i = stack_fill[which] - 1; i >= 0; i--)
                add_report(tsce_pkg::STAT_ELEMENT, stack_mem[which][i]);
        end
    endfunction

    function automatic void apply_stack_action(stack_op_t op);
        int k;
        int tgt;
        int src_top;
        bit cut_short;
        stack_report_t rp;
        item_reports.delete();
        case (op.act)
            tsce_pkg::ACT_PUSH: begin
                push_entry(STK_S, op.value);
            end
            tsce_pkg::ACT_POP: begin
                if (stack_fill[STK_S] == 0) begin
                    add_report(tsce_pkg::STAT_UNDERFLOW, '0);
                end else begin
                    stack_fill[STK_S]--;
                    add_report(tsce_pkg::STAT_POPPED, stack_mem[STK_S][stack_fill[STK_S]]);
                end
            end
            tsce_pkg::ACT_DISP: begin
                if (op.sel == tsce_pkg::SEL_BAD)
                    add_report(tsce_pkg::STAT_INVALID, '0);
                else
                    list_stack(int'(op.sel));
            end
            default: begin
                // A copy to S itself or to the invalid selector does nothing at all.
                if (op.sel == tsce_pkg::SEL_P || op.sel == tsce_pkg::SEL_Q) begin
                    tgt = int'(op.sel);
                    src_top = stack_fill[STK_S];
                    cut_short = 1'b0;
                    for (k = 0; k < int'(op.cnt) && !cut_short; k++) begin
                        if (k >= src_top) begin
                            add_report(tsce_pkg::STAT_SHORT, '0);
                            cut_short = 1'b1;
                        end else begin
                            push_entry(tgt, stack_mem[STK_S][src_top - 1 - k]);
                        end
                    end
                    if (!cut_short)
                        list_stack(tgt);
                end
            end
        endcase
        if (item_reports.size() > 0) begin
            rp = item_reports.pop_back();
            rp.last = 1'b1;
            item_reports.push_back(rp);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic stack_op_t make_op(tsce_pkg::action_t a, tsce_pkg::data_t v,
                                          tsce_pkg::sel_t s, int c);
        stack_op_t op;
        op.act   = a;
        op.value = v;
        op.sel   = s;
        op.cnt   = tsce_pkg::count_t'(c);
        return op;
    endfunction

    function automatic directed_row_t op_row(tsce_pkg::action_t a, tsce_pkg::data_t v,
                                             tsce_pkg::sel_t s, int c, int reps);
        directed_row_t r;
        r.op = make_op(a, v, s, c);
        r.reps = reps;
        r.typed = 1'b0;
        r.typed_report = '0;
        return r;
    endfunction

    function automatic directed_row_t checked_row(tsce_pkg::action_t a, tsce_pkg::data_t v,
                                                  tsce_pkg::sel_t s, int c,
                                                  tsce_pkg::status_t st,
                                                  tsce_pkg::data_t d);
        directed_row_t r;
        r = op_row(a, v, s, c, 1);
        r.typed = 1'b1;
        r.typed_report.status = st;
        r.typed_report.data   = d;
        r.typed_report.last   = 1'b1;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic tsce_pkg::data_t pick_value();
        if ($urandom_range(0, 7) != 0)
            return tsce_pkg::data_t'($urandom);
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mode 0 leans toward filling S, mode 2 toward draining it.
    function automatic stack_op_t random_op(int mode);
        stack_op_t op;
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        push_lim = (mode == 0) ? 55 : (mode == 1) ? 35 : 15;
        pop_lim  = push_lim + ((mode == 0) ? 10 : (mode == 1) ? 25 : 45);
        op.value = pick_value();
        op.sel   = tsce_pkg::sel_t'($urandom_range(0, 3));
        op.cnt   = tsce_pkg::count_t'($urandom_range(0, 31));
        if (r < push_lim) begin
            op.act = tsce_pkg::ACT_PUSH;
        end else if (r < pop_lim) begin
            op.act = tsce_pkg::ACT_POP;
        end else if (r < pop_lim + 20) begin
            op.act = tsce_pkg::ACT_DISP;
        end else begin
            op.act = tsce_pkg::ACT_COPY;
            if ($urandom_range(0, 99) < 85)
                op.sel = ($urandom_range(0, 1) != 0) ? tsce_pkg::SEL_P : tsce_pkg::SEL_Q;
            if ($urandom_range(0, 99) < 75)
                op.cnt = tsce_pkg::count_t'($urandom_range(0, tsce_pkg::DEPTH + 1));
        end
        return op;
    endfunction

    task automatic send_op(stack_op_t op, logic typed, stack_report_t typed_report);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= op.act;
        s_value     <= op.value;
        s_stack_sel <= op.sel;
        s_count     <= op.cnt;
        do @(posedge aclk); while (!s_ready);
        apply_stack_action(op);
        if (typed) begin
            item_reports.delete();
            item_reports.push_back(typed_report);
        end
        foreach (item_reports[i])
            reports_owed.push_back(item_reports[i]);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        while (reports_owed.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // ---------------------------------------------------------------- result side

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_ready <= 1'b1;
            end else if (rx_roll < 97) begin
                m_ready <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b0;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        stack_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reports_owed.size() == 0) begin
                log_mismatch($sformatf("result with nothing outstanding: status %0d data %h last %b",
                                       m_status, m_data, m_last));
            end else begin
                want = reports_owed.pop_front();
                results_checked++;
                if (want.status == tsce_pkg::STAT_OVERFLOW)
                    overflows_seen++;
                if (want.status == tsce_pkg::STAT_SHORT)
                    shorts_seen++;
                if (m_status !== want.status || m_data !== want.data || m_last !== want.last)
                    log_mismatch($sformatf(
                        "expected status %0d data %h last %b, got status %0d data %h last %b",
                        want.status, want.data, want.last, m_status, m_data, m_last));
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : main_sequence
        int rows_done;
        int counted;
        int mode;
        stack_op_t op;
        stack_op_t rep_op;

        foreach (stack_fill[i])
            stack_fill[i] = 0;

        directed_rows = '{
            checked_row(tsce_pkg::ACT_POP,  '0, tsce_pkg::SEL_S,   0,
                        tsce_pkg::STAT_UNDERFLOW, '0),
            checked_row(tsce_pkg::ACT_DISP, '0, tsce_pkg::SEL_S,   0,
                        tsce_pkg::STAT_EMPTY, '0),
            checked_row(tsce_pkg::ACT_DISP, '0, tsce_pkg::SEL_P,   0,
                        tsce_pkg::STAT_EMPTY, '0),
            checked_row(tsce_pkg::ACT_DISP, '0, tsce_pkg::SEL_Q,   0,
                        tsce_pkg::STAT_EMPTY, '0),
            checked_row(tsce_pkg::ACT_DISP, '0, tsce_pkg::SEL_BAD, 0,
                        tsce_pkg::STAT_INVALID, '0),
            checked_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_P,   0,
                        tsce_pkg::STAT_EMPTY, '0),
            op_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_S,   5,  1),
            op_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_BAD, 31, 1),
            op_row(tsce_pkg::ACT_PUSH, 32'h7FFF_FFFF, tsce_pkg::SEL_BAD, 31, 1),
            checked_row(tsce_pkg::ACT_POP, '0, tsce_pkg::SEL_S, 0,
                        tsce_pkg::STAT_POPPED, 32'h7FFF_FFFF),
            op_row(tsce_pkg::ACT_PUSH, 32'h8000_0000, tsce_pkg::SEL_S, 0, 1),
            checked_row(tsce_pkg::ACT_POP, '0, tsce_pkg::SEL_S, 0,
                        tsce_pkg::STAT_POPPED, 32'h8000_0000),
            checked_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_Q, 3,
                        tsce_pkg::STAT_SHORT, '0),
            op_row(tsce_pkg::ACT_PUSH, 32'hFFFF_FFFF, tsce_pkg::SEL_S, 0, 1),
            op_row(tsce_pkg::ACT_PUSH, 32'h0000_0100, tsce_pkg::SEL_S, 0, tsce_pkg::DEPTH - 1),
            checked_row(tsce_pkg::ACT_PUSH, 32'h1234_5678, tsce_pkg::SEL_S, 0,
                        tsce_pkg::STAT_OVERFLOW, '0),
            op_row(tsce_pkg::ACT_DISP, '0, tsce_pkg::SEL_S, 0,  1),
            op_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_P, 16, 1),
            op_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_P, 3,  1),
            op_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_Q, 31, 1),
            op_row(tsce_pkg::ACT_COPY, '0, tsce_pkg::SEL_Q, 16, 1),
            op_row(tsce_pkg::ACT_POP,  '0, tsce_pkg::SEL_S, 0,  tsce_pkg::DEPTH + 1),
            op_row(tsce_pkg::ACT_DISP, '0, tsce_pkg::SEL_P, 0,  1),
            op_row(tsce_pkg::ACT_DISP, '0, tsce_pkg::SEL_Q, 0,  1)
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Repeated push rows step the value so each entry is distinct.
        for (rows_done = 0; rows_done < directed_rows.size(); rows_done++) begin
            for (int r = 0; r < directed_rows[rows_done].reps; r++) begin
                rep_op = directed_rows[rows_done].op;
                rep_op.value = rep_op.value + tsce_pkg::data_t'(r);
                send_op(rep_op, directed_rows[rows_done].typed,
                        directed_rows[rows_done].typed_report);
            end
        end
        directed_items = items_sent;

        s_valid <= 1'b0;
        wait_for_drain();

        counted = 0;
        mode = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 30 == 0)
                mode = $urandom_range(0, 2);
            calm = (counted >= 100 && counted < 140);
            if (counted == 180) begin
                s_valid <= 1'b0;
                wait_for_drain();
            end
            op = random_op(mode);
            send_op(op, 1'b0, '0);
            if (!(op.act == tsce_pkg::ACT_COPY &&
                  (op.sel == tsce_pkg::SEL_S || op.sel == tsce_pkg::SEL_BAD)))
                counted++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (reports_owed.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", reports_owed.size()));

        $display("Sent %0d items (%0d directed) across push, pop, display and copy.",
                 items_sent, directed_items);
        $display("Checked %0d results, %0d of them overflows and %0d short copies; %0d mismatches.",
                 results_checked, overflows_seen, shorts_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
